// ===== sv/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the one-wire bus master: bus phases, command
// codes, queue entry, timing register set and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // Bus phases of the back-end sequencer
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LOW = 4'd1,
    PH_RST_WT  = 4'd2,
    PH_RST_REC = 4'd3,
    PH_WR_LOW  = 4'd4,
    PH_WR_HIGH = 4'd5,
    PH_RD_LOW  = 4'd6,
    PH_RD_WT   = 4'd7,
    PH_RD_REC  = 4'd8
  } phase_t;

  // Command carried by one tick transaction
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // One classified tick waiting in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wbyte;
    logic       level;
  } owbm_item_t;

  // Timing register set
  typedef struct packed {
    logic [15:0] reset_low;
    logic [15:0] presence_wait;
    logic [15:0] reset_recover;
    logic [15:0] short_low;
    logic [15:0] long_low;
    logic [15:0] slot_recover;
    logic [15:0] read_sample;
  } owbm_timing_t;

  // Register map (word index = paddr[4:2])
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_LONG_LOW      = 3'd4;
  localparam logic [2:0] REG_SLOT_RECOVER  = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;

  // Reset values of the timing registers
  localparam logic [15:0] RST_RESET_LOW     = 16'd480;
  localparam logic [15:0] RST_PRESENCE_WAIT = 16'd55;
  localparam logic [15:0] RST_RESET_RECOVER = 16'd480;
  localparam logic [15:0] RST_SHORT_LOW     = 16'd2;
  localparam logic [15:0] RST_LONG_LOW      = 16'd60;
  localparam logic [15:0] RST_SLOT_RECOVER  = 16'd58;
  localparam logic [15:0] RST_READ_SAMPLE   = 16'd1;

  localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

`default_nettype wire

// ===== sv/owbm_if.sv =====
// ----------------------------------------------------------------------------
// owbm_if
// Valid/ready channels of the one-wire bus master: tick input and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] write_byte;
  logic       line_level;

  modport source (output valid, output mode, output write_byte, output line_level,
                  input ready);
  modport sink   (input valid, input mode, input write_byte, input line_level,
                  output ready);
endinterface

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       pull_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, output pull_low, output busy_res, output done_res,
                  output presence, output read_data, input ready);
  modport sink   (input valid, input pull_low, input busy_res, input done_res,
                  input presence, input read_data, output ready);
endinterface

`default_nettype wire

// ===== sv/owbm_cfg.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg
// APB register bank holding the seven bus timing tick counts.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg
  import owbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready,
  output      owbm_timing_t      timing
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.reset_low     <= RST_RESET_LOW;
      timing.presence_wait <= RST_PRESENCE_WAIT;
      timing.reset_recover <= RST_RESET_RECOVER;
      timing.short_low     <= RST_SHORT_LOW;
      timing.long_low      <= RST_LONG_LOW;
      timing.slot_recover  <= RST_SLOT_RECOVER;
      timing.read_sample   <= RST_READ_SAMPLE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RESET_LOW:     timing.reset_low     <= pwdata[15:0];
        REG_PRESENCE_WAIT: timing.presence_wait <= pwdata[15:0];
        REG_RESET_RECOVER: timing.reset_recover <= pwdata[15:0];
        REG_SHORT_LOW:     timing.short_low     <= pwdata[15:0];
        REG_LONG_LOW:      timing.long_low      <= pwdata[15:0];
        REG_SLOT_RECOVER:  timing.slot_recover  <= pwdata[15:0];
        REG_READ_SAMPLE:   timing.read_sample   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_RESET_LOW:     prdata = {16'd0, timing.reset_low};
      REG_PRESENCE_WAIT: prdata = {16'd0, timing.presence_wait};
      REG_RESET_RECOVER: prdata = {16'd0, timing.reset_recover};
      REG_SHORT_LOW:     prdata = {16'd0, timing.short_low};
      REG_LONG_LOW:      prdata = {16'd0, timing.long_low};
      REG_SLOT_RECOVER:  prdata = {16'd0, timing.slot_recover};
      REG_READ_SAMPLE:   prdata = {16'd0, timing.read_sample};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/owbm_front.sv =====
// ----------------------------------------------------------------------------
// owbm_front
// Front end: accepts tick transactions, classifies the mode into a command
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_front
  import owbm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  owbm_in_if.sink     in_ch,
  output logic        head_valid,
  output owbm_item_t  head_item,
  input  wire logic   pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  owbm_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;
  owbm_item_t       new_item;

  // Classify the incoming mode
  always_comb begin
    case (in_ch.mode)
      CMD_RESET: new_item.cmd = CMD_RESET;
      CMD_WRITE: new_item.cmd = CMD_WRITE;
      CMD_READ:  new_item.cmd = CMD_READ;
      default:   new_item.cmd = CMD_TICK;
    endcase
    new_item.wbyte = in_ch.write_byte;
    new_item.level = in_ch.line_level;
  end

  assign in_ch.ready = (count != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count != '0);
  assign do_pop      = pop && head_valid;
  assign head_item   = entries[rd_ptr];

  // Store the classified tick
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    (pop && !head_valid && !push) |=> (count == '0))
    else $error("pop from empty queue changed occupancy");

endmodule

`default_nettype wire

// ===== sv/owbm_back.sv =====
// ----------------------------------------------------------------------------
// owbm_back
// Back end: bus phase sequencer that executes one queued tick per cycle while
// its output register is free or being read out, and holds the result in it.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_back
  import owbm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire owbm_timing_t  timing,
  input  wire logic          head_valid,
  input  wire owbm_item_t    head_item,
  output logic               pop,
  owbm_out_if.source         out_ch
);

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        presence_flag, presence_flag_next;
  logic [7:0]  read_result, read_result_next;

  phase_t      eff;
  phase_t      follow;
  logic [15:0] tc;
  logic [2:0]  bi;
  logic [7:0]  sb;
  logic [7:0]  sb_samp;
  logic [15:0] len;
  logic        slot_end;
  logic        last;
  logic        pull_w, busy_w, done_w;
  logic        out_valid;

  assign pop = head_valid && (!out_valid || out_ch.ready);

  // Resolve the phase of this tick, starting a command when idle
  always_comb begin
    eff = phase;
    tc  = tick_count;
    bi  = bit_index;
    sb  = shift_byte;
    if (phase == PH_IDLE) begin
      tc = '0;
      bi = '0;
      case (head_item.cmd)
        CMD_RESET: eff = PH_RST_LOW;
        CMD_WRITE: begin
          eff = PH_WR_LOW;
          sb  = head_item.wbyte;
        end
        CMD_READ: begin
          eff = PH_RD_LOW;
          sb  = 8'd0;
        end
        default: begin
          tc = tick_count;
          bi = bit_index;
        end
      endcase
    end
  end

  // Select phase length and the phase that follows
  always_comb begin
    len      = 16'd1;
    follow   = PH_IDLE;
    slot_end = 1'b0;
    sb_samp  = sb;
    case (eff)
      PH_RST_LOW: begin
        len    = timing.reset_low;
        follow = PH_RST_WT;
      end
      PH_RST_WT: begin
        len    = timing.presence_wait;
        follow = PH_RST_REC;
      end
      PH_RST_REC: begin
        len    = timing.reset_recover;
        follow = PH_IDLE;
      end
      PH_WR_LOW: begin
        len    = sb[0] ? timing.short_low : timing.long_low;
        follow = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        len      = sb[0] ? timing.slot_recover : timing.short_low;
        follow   = (bi == LAST_BIT) ? PH_IDLE : PH_WR_LOW;
        slot_end = 1'b1;
      end
      PH_RD_LOW: begin
        len    = timing.short_low;
        follow = PH_RD_WT;
      end
      PH_RD_WT: begin
        len    = timing.read_sample;
        follow = PH_RD_REC;
      end
      PH_RD_REC: begin
        if (tc == 16'd0) begin
          sb_samp = {head_item.level, sb[7:1]};
        end
        len      = timing.slot_recover;
        follow   = (bi == LAST_BIT) ? PH_IDLE : PH_RD_LOW;
        slot_end = 1'b1;
      end
      default: begin
        len    = 16'd1;
        follow = PH_IDLE;
      end
    endcase
  end

  // A zero length counts as one tick
  assign last = ({1'b0, tc} + 17'd1) >= {1'b0, len};

  // Next state of the sequencer
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    read_result_next   = read_result;
    if (eff != PH_IDLE) begin
      shift_byte_next = sb_samp;
      bit_index_next  = bi;
      phase_next      = eff;
      if (eff == PH_RST_REC && tc == 16'd0) begin
        presence_flag_next = !head_item.level;
      end
      if (last) begin
        tick_count_next = '0;
        phase_next      = follow;
        if (eff == PH_WR_HIGH) begin
          shift_byte_next = {1'b0, sb_samp[7:1]};
        end
        if (slot_end) begin
          bit_index_next = (follow == PH_IDLE) ? 3'd0 : bi + 3'd1;
        end
        if (eff == PH_RD_REC && follow == PH_IDLE) begin
          read_result_next = sb_samp;
        end
      end else begin
        tick_count_next = tc + 16'd1;
      end
    end else begin
      phase_next = PH_IDLE;
    end
  end

  // Bus drive and status of this tick
  always_comb begin
    case (eff)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: pull_w = 1'b1;
      default:                          pull_w = 1'b0;
    endcase
    busy_w = (eff != PH_IDLE);
    done_w = busy_w && last && (follow == PH_IDLE);
  end

  // Update sequencer state on each executed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      read_result   <= '0;
    end else if (pop) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      read_result   <= read_result_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.pull_low  <= pull_w;
      out_ch.busy_res  <= busy_w;
      out_ch.done_res  <= done_w;
      out_ch.presence  <= presence_flag_next;
      out_ch.read_data <= read_result_next;
    end
  end

  assign out_ch.valid = out_valid;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.done_res) |-> out_ch.busy_res)
    else $error("done reported outside a command");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && done_w) |=> (phase == PH_IDLE && bit_index == 3'd0))
    else $error("sequencer not idle after command completion");

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one tick transaction per cycle unless stalled:
// bus reset with presence detect, byte write and byte read, all register timed.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  in_ch    | in  | valid/ready         | mode, write_byte, line_level
//  out_ch   | out | valid/ready         | pull_low, busy_res, done_res, presence,
//           |     |                     | read_data
//  apb      | in  | psel/penable/pready | paddr, pwdata, prdata (timing regs)
//
//  One tick per cycle sustained while out_ch takes results; a result appears in
//  the cycle after its tick leaves the queue.
//  The phase sequencer in the back end is the only per-tick loop.
//  Synchronous reset returns the sequencer to idle and timing to defaults.
//  A stalled output holds its register; the queue absorbs QUEUE_DEPTH ticks
//  before in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  owbm_in_if.sink                in_ch,
  owbm_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  owbm_timing_t timing;
  logic         head_valid;
  owbm_item_t   head_item;
  logic         pop;

  owbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .timing  (timing)
  );

  owbm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  owbm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .timing     (timing),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/owbm_checker.sv =====
// ----------------------------------------------------------------------------
// owbm_checker
// Watches the tick and result channels and the timing register port of the
// one-wire bus master, predicts the result of every accepted tick from its
// own copy of the bus sequencer and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module owbm_checker
  import owbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  owbm_in_if                     in_mon,
  owbm_out_if                    out_mon,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output int                     fails,
  output int                     outstanding,
  output logic                   seq_idle
);

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } tick_res_t;

  // Shadow timing registers and sequencer state
  owbm_timing_t timing;
  phase_t       bus_phase;
  logic [15:0]  slot_count;
  logic [2:0]   bit_pos;
  logic [7:0]   shift_reg;
  logic         presence_seen;
  logic [7:0]   last_read;

  tick_res_t tick_results_q[$];
  int        err_cnt = 0;

  assign fails = err_cnt;

  // Advance the shadow sequencer by one bus tick and build its result
  task automatic step_sequencer(input cmd_t m, input logic [7:0] wb, input logic lvl,
                                output tick_res_t r);
    logic [15:0] span;
    phase_t      nxt;
    logic        lsb;
    logic        reading;
    r    = '0;
    span = 16'd1;

    // Start a command only from idle
    if (bus_phase == PH_IDLE && m != CMD_TICK) begin
      slot_count = '0;
      bit_pos    = '0;
      case (m)
        CMD_RESET: bus_phase = PH_RST_LOW;
        CMD_WRITE: begin
          shift_reg = wb;
          bus_phase = PH_WR_LOW;
        end
        default: begin
          shift_reg = '0;
          bus_phase = PH_RD_LOW;
        end
      endcase
    end

    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      nxt        = bus_phase;
      lsb        = shift_reg[0];
      case (bus_phase)
        PH_RST_LOW: begin
          r.pull_low = 1'b1;
          span       = timing.reset_low;
          nxt        = PH_RST_WT;
        end
        PH_RST_WT: begin
          span = timing.presence_wait;
          nxt  = PH_RST_REC;
        end
        PH_RST_REC: begin
          if (slot_count == 16'd0) presence_seen = ~lvl;
          span = timing.reset_recover;
          nxt  = PH_IDLE;
        end
        PH_WR_LOW: begin
          r.pull_low = 1'b1;
          span       = lsb ? timing.short_low : timing.long_low;
          nxt        = PH_WR_HIGH;
        end
        PH_WR_HIGH: span = lsb ? timing.slot_recover : timing.short_low;
        PH_RD_LOW: begin
          r.pull_low = 1'b1;
          span       = timing.short_low;
          nxt        = PH_RD_WT;
        end
        PH_RD_WT: begin
          span = timing.read_sample;
          nxt  = PH_RD_REC;
        end
        default: begin
          if (slot_count == 16'd0) shift_reg = {lvl, shift_reg[7:1]};
          span = timing.slot_recover;
        end
      endcase

      // A zero span ends the phase after one tick, like a span of one
      if (({1'b0, slot_count} + 17'd1) >= {1'b0, span}) begin
        slot_count = '0;
        if (bus_phase == PH_WR_HIGH || bus_phase == PH_RD_REC) begin
          reading = (bus_phase == PH_RD_REC);
          if (!reading) shift_reg = shift_reg >> 1;
          if (bit_pos == LAST_BIT) begin
            if (reading) last_read = shift_reg;
            bus_phase  = PH_IDLE;
            bit_pos    = '0;
            r.done_res = 1'b1;
          end else begin
            bit_pos   = bit_pos + 3'd1;
            bus_phase = reading ? PH_RD_LOW : PH_WR_LOW;
          end
        end else begin
          if (nxt == PH_IDLE) r.done_res = 1'b1;
          bus_phase = nxt;
        end
      end else begin
        slot_count = slot_count + 16'd1;
      end
    end

    r.presence  = presence_seen;
    r.read_data = last_read;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Track register writes, retire results, then predict the accepted tick
  always @(posedge clk) begin
    tick_res_t want;
    if (rst) begin
      timing = '{reset_low:     RST_RESET_LOW,
                 presence_wait: RST_PRESENCE_WAIT,
                 reset_recover: RST_RESET_RECOVER,
                 short_low:     RST_SHORT_LOW,
                 long_low:      RST_LONG_LOW,
                 slot_recover:  RST_SLOT_RECOVER,
                 read_sample:   RST_READ_SAMPLE};
      bus_phase     = PH_IDLE;
      slot_count    = '0;
      bit_pos       = '0;
      shift_reg     = '0;
      presence_seen = 1'b0;
      last_read     = '0;
      tick_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_RESET_LOW:     timing.reset_low     = pwdata[15:0];
          REG_PRESENCE_WAIT: timing.presence_wait = pwdata[15:0];
          REG_RESET_RECOVER: timing.reset_recover = pwdata[15:0];
          REG_SHORT_LOW:     timing.short_low     = pwdata[15:0];
          REG_LONG_LOW:      timing.long_low      = pwdata[15:0];
          REG_SLOT_RECOVER:  timing.slot_recover  = pwdata[15:0];
          REG_READ_SAMPLE:   timing.read_sample   = pwdata[15:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result transaction with no tick pending");
          err_cnt++;
        end else begin
          want = tick_results_q.pop_front();
          compare_field("pull_low", want.pull_low, out_mon.pull_low);
          compare_field("busy_res", want.busy_res, out_mon.busy_res);
          compare_field("done_res", want.done_res, out_mon.done_res);
          compare_field("presence", want.presence, out_mon.presence);
          compare_field("read_data", want.read_data, out_mon.read_data);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        step_sequencer(cmd_t'(in_mon.mode), in_mon.write_byte, in_mon.line_level, want);
        tick_results_q.push_back(want);
      end
    end
    outstanding <= tick_results_q.size();
    seq_idle    <= (bus_phase == PH_IDLE);
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives bus ticks and timing register writes into the one-wire bus master:
// directed resets, writes and reads at partly default, zero, unit and uneven
// timings, then random command streams with noise under several idle and
// stall patterns. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import owbm_pkg::*;

  localparam int         LINE_LOW   = 0;
  localparam int         LINE_HIGH  = 1;
  localparam int         LINE_RAND  = 2;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int         HOLD_TICKS = 300;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int   fails;
  int   outstanding;
  logic seq_idle;

  int tx_idle_pct;
  int rx_stall_pct;
  int noise_pct;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  owbm_in_if  in_ch ();
  owbm_out_if out_ch ();

  one_wire_bus_master u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  owbm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fails       (fails),
    .outstanding (outstanding),
    .seq_idle    (seq_idle)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drive result ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_TICKS;
      out_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic line_bit(input int lm);
    if (lm == LINE_LOW) return 1'b0;
    if (lm == LINE_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  function automatic logic [15:0] small_span();
    if ($urandom_range(15) == 0) return 16'd0;
    return 16'($urandom_range(1, 2));
  endfunction

  // Offer one tick transaction and hold it until accepted
  task automatic push_tick(input cmd_t m, input logic [7:0] b, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.write_byte <= b;
    in_ch.line_level <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Issue a command, then tick until the sequencer is back to idle
  task automatic run_cmd(input cmd_t c, input logic [7:0] b, input int lm);
    cmd_t m;
    push_tick(c, b, line_bit(lm));
    do begin
      m = CMD_TICK;
      if ($urandom_range(99) < noise_pct) m = cmd_t'($urandom_range(3));
      push_tick(m, 8'($urandom), line_bit(lm));
    end while (!seq_idle);
  endtask

  // Tick to idle, then drop valid and wait for every result
  task automatic settle();
    do begin
      push_tick(CMD_TICK, 8'($urandom), 1'($urandom));
    end while (!seq_idle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // One write transaction on the register port; psel stays high for the next
  task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_timing(input owbm_timing_t t);
    reg_write(REG_RESET_LOW, t.reset_low);
    reg_write(REG_PRESENCE_WAIT, t.presence_wait);
    reg_write(REG_RESET_RECOVER, t.reset_recover);
    reg_write(REG_SHORT_LOW, t.short_low);
    reg_write(REG_LONG_LOW, t.long_low);
    reg_write(REG_SLOT_RECOVER, t.slot_recover);
    reg_write(REG_READ_SAMPLE, t.read_sample);
    // Out-of-map index must leave every register alone
    reg_write(REG_UNUSED, 16'($urandom));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    owbm_timing_t tm;
    int           r;
    int           lm;

    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.mode       = CMD_TICK;
    in_ch.write_byte = '0;
    in_ch.line_level = 1'b1;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    noise_pct        = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Idle ticks, then reset and read on the default presence and read timing
    repeat (3) push_tick(CMD_TICK, 8'hFF, 1'b0);
    settle();
    reg_write(REG_RESET_LOW, 16'd1);
    reg_write(REG_RESET_RECOVER, 16'd1);
    reg_write(REG_SLOT_RECOVER, 16'd1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    run_cmd(CMD_RESET, 8'h00, LINE_LOW);
    noise_pct = 30;
    run_cmd(CMD_READ, 8'hFF, LINE_RAND);
    noise_pct = 0;
    settle();

    // Zero spans behave as one tick
    load_timing('0);
    run_cmd(CMD_WRITE, 8'hA5, LINE_RAND);
    run_cmd(CMD_READ, 8'h00, LINE_RAND);
    run_cmd(CMD_RESET, 8'h00, LINE_LOW);
    settle();

    // Minimum legal spans
    load_timing('{default: 16'd1});
    run_cmd(CMD_WRITE, 8'h5A, LINE_RAND);
    run_cmd(CMD_READ, 8'h00, LINE_RAND);
    run_cmd(CMD_RESET, 8'h00, LINE_HIGH);
    settle();

    // Uneven spans so that write-one and write-zero slots differ
    tm = '{default: 16'd1};
    tm.long_low     = 16'd3;
    tm.slot_recover = 16'd2;
    tm.read_sample  = 16'd2;
    load_timing(tm);
    run_cmd(CMD_WRITE, 8'h0F, LINE_RAND);
    run_cmd(CMD_READ, 8'h00, LINE_RAND);
    settle();

    // Random command streams under each idle and stall pattern
    noise_pct = 10;
    for (int round = 0; round < 4; round++) begin
      tm = '{reset_low: small_span(), presence_wait: small_span(),
             reset_recover: small_span(), short_low: small_span(),
             long_low: small_span(), slot_recover: small_span(),
             read_sample: small_span()};
      load_timing(tm);
      case (round % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 57;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 57;
        end
        default: begin
          tx_idle_pct = 23;
          rx_stall_pct <= 23;
        end
      endcase
      repeat (6)
        push_tick(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
      for (int k = 0; k < 2; k++) begin
        // Hold off the receiver while ticks keep coming
        if (k == 1) hold_seq <= hold_seq + 1;
        r  = $urandom_range(99);
        lm = LINE_RAND;
        if (r < 10) lm = LINE_LOW;
        else if (r < 20) lm = LINE_HIGH;
        run_cmd(cmd_t'($urandom_range(1, 3)), 8'($urandom), lm);
      end
      settle();
    end

    // Drain and give the verdict
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    settle();
    repeat (8) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
